// ===== rtl/core/png_scanline_unfilter_top_macros.svh =====
// Assertion macros for the PNG scanline unfilter.
// Needs clk_i and rst_ni in the scope of every use.
`ifndef PNG_SCANLINE_UNFILTER_TOP_MACROS_SVH
`define PNG_SCANLINE_UNFILTER_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PSU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define PSU_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define PSU_ASSERT(lbl, prop, msg)
`define PSU_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// ===== rtl/core/psu_pkg.sv =====
// Shared types and constants of the PNG scanline unfilter.
// No dependencies.
`default_nettype none
package psu_pkg;

  localparam int MAX_ROW_BYTES = 8192;
  localparam int COL_W         = $clog2(MAX_ROW_BYTES);
  localparam int PIX_W         = 3;
  localparam int RB_W          = 14;
  localparam int RC_W          = 16;
  localparam int CFG_DATA_W    = 16;
  localparam int FIFO_DEPTH    = 4;

  typedef enum logic [1:0] {
    CFG_PIXEL_BYTES = 2'd0,
    CFG_ROW_BYTES   = 2'd1,
    CFG_ROW_COUNT   = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4
  } filt_e;

  typedef struct packed {
    logic [1:0]      pix_sel;
    logic [RB_W-1:0] row_bytes;
    logic [RC_W-1:0] row_count;
  } cfg_t;

  typedef struct packed {
    logic             is_err;
    logic [7:0]       data;
    logic [COL_W-1:0] col;
    logic             row_start;
    logic             first_row;
    filt_e            filt;
    logic             row_end;
    logic             image_end;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_st_t;

endpackage
`default_nettype wire

// ===== rtl/core/psu_if.sv =====
// Handshake interfaces: input byte beats, result beats, config writes.
// Depends on psu_pkg.
`default_nettype none
interface psu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;
  modport source (output valid, output stream_byte, input ready);
  modport sink   (input valid, input stream_byte, output ready);
endinterface

interface psu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_byte;
  logic       row_end;
  logic       image_end;
  logic       bad_filter;
  modport source (output valid, output pixel_byte, output row_end, output image_end,
                  output bad_filter, input ready);
  modport sink   (input valid, input pixel_byte, input row_end, input image_end,
                  input bad_filter, output ready);
endinterface

interface psu_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       index;
  logic [psu_pkg::CFG_DATA_W-1:0]   data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/psu_front.sv =====
// Front end: tracks row/column position and filter type, queues data beats.
// Depends on psu_pkg.
`default_nettype none
module psu_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire psu_pkg::cfg_t     cfg_i,
  input  wire logic              in_valid_i,
  input  wire logic [7:0]        in_byte_i,
  output logic                   in_ready_o,
  input  wire psu_pkg::fifo_st_t fifo_st_i,
  output logic                   push_o,
  output psu_pkg::entry_t        entry_o
);

  logic                      awaiting_q, awaiting_d;
  logic [psu_pkg::COL_W-1:0] col_q, col_d;
  logic [psu_pkg::RC_W-1:0]  row_q, row_d;
  logic                      first_q, first_d;
  logic                      err_q, err_d;
  psu_pkg::filt_e            filt_q, filt_d;
  logic                      acc, last_col, last_row;

  assign in_ready_o = !fifo_st_i.full;
  assign acc        = in_valid_i && in_ready_o;
  assign last_col   = (32'(col_q) + 32'd1) >= 32'(cfg_i.row_bytes);
  assign last_row   = (32'(row_q) + 32'd1) >= 32'(cfg_i.row_count);

  always_comb begin
    awaiting_d = awaiting_q;
    col_d      = col_q;
    row_d      = row_q;
    first_d    = first_q;
    err_d      = err_q;
    filt_d     = filt_q;
    push_o     = 1'b0;
    entry_o    = '0;
    entry_o.data      = in_byte_i;
    entry_o.col       = col_q;
    entry_o.row_start = (col_q == '0);
    entry_o.first_row = first_q;
    entry_o.filt      = filt_q;
    entry_o.row_end   = last_col;
    entry_o.image_end = last_col && last_row;
    if (acc) begin
      if (awaiting_q) begin
        awaiting_d = 1'b0;
        col_d      = '0;
        if (!err_q) begin
          if (in_byte_i > 8'd4) begin
            err_d          = 1'b1;
            push_o         = 1'b1;
            entry_o        = '0;
            entry_o.is_err = 1'b1;
          end else begin
            filt_d = psu_pkg::filt_e'(in_byte_i[2:0]);
          end
        end
      end else begin
        push_o = !err_q;
        if (last_col) begin
          awaiting_d = 1'b1;
          col_d      = '0;
          if (last_row) begin
            row_d   = '0;
            first_d = 1'b1;
            err_d   = 1'b0;
          end else begin
            row_d   = row_q + 1'b1;
            first_d = 1'b0;
          end
        end else begin
          col_d = col_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      awaiting_q <= 1'b1;
      col_q      <= '0;
      row_q      <= '0;
      first_q    <= 1'b1;
      err_q      <= 1'b0;
      filt_q     <= psu_pkg::FILT_NONE;
    end else begin
      awaiting_q <= awaiting_d;
      col_q      <= col_d;
      row_q      <= row_d;
      first_q    <= first_d;
      err_q      <= err_d;
      filt_q     <= filt_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/psu_fifo.sv =====
// Short flop queue between front and back ends.
// Depends on psu_pkg.
`default_nettype none
module psu_fifo (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire psu_pkg::entry_t entry_i,
  input  wire logic            pop_i,
  output psu_pkg::entry_t      head_o,
  output psu_pkg::fifo_st_t    status_o
);

  localparam int PTR_W = $clog2(psu_pkg::FIFO_DEPTH);
  localparam int CNT_W = $clog2(psu_pkg::FIFO_DEPTH + 1);

  psu_pkg::entry_t  mem_q [psu_pkg::FIFO_DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign status_o.full  = (cnt_q == CNT_W'(psu_pkg::FIFO_DEPTH));
  assign status_o.empty = (cnt_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign head_o         = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= entry_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (32'(wr_q) == psu_pkg::FIFO_DEPTH - 1) ? '0 : wr_q + 1'b1;
      if (do_pop)  rd_q <= (32'(rd_q) == psu_pkg::FIFO_DEPTH - 1) ? '0 : rd_q + 1'b1;
      unique case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/psu_back.sv =====
// Back end: line store read, prediction, reconstruction and result register.
// Depends on psu_pkg and psu_if.
`default_nettype none
module psu_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [1:0]        pix_sel_i,
  input  wire psu_pkg::entry_t   head_i,
  input  wire psu_pkg::fifo_st_t fifo_st_i,
  output logic                   pop_o,
  psu_out_if.source              out_o
);

  function automatic logic [7:0] predict(psu_pkg::filt_e f, logic [7:0] a,
                                         logic [7:0] b, logic [7:0] c);
    logic signed [10:0] pa, pb, pc, da, db, dc;
    logic [8:0]         s;
    da = $signed({3'b0, b}) - $signed({3'b0, c});
    db = $signed({3'b0, a}) - $signed({3'b0, c});
    dc = $signed({3'b0, a}) + $signed({3'b0, b}) - $signed({2'b0, c, 1'b0});
    pa = (da < 0) ? -da : da;
    pb = (db < 0) ? -db : db;
    pc = (dc < 0) ? -dc : dc;
    s  = {1'b0, a} + {1'b0, b};
    unique case (f)
      psu_pkg::FILT_SUB:   predict = a;
      psu_pkg::FILT_UP:    predict = b;
      psu_pkg::FILT_AVG:   predict = s[8:1];
      psu_pkg::FILT_PAETH: begin
        if (pa <= pb && pa <= pc) predict = a;
        else if (pb <= pc)        predict = b;
        else                      predict = c;
      end
      default:             predict = 8'd0;
    endcase
  endfunction

  logic [7:0]      line_mem [psu_pkg::MAX_ROW_BYTES];
  logic [7:0]      rd_q, byp_data_q;
  logic            byp_q;
  psu_pkg::entry_t r_q;
  logic            r_vld_q, o_vld_q;
  logic [31:0]     win_a_q, win_c_q, a_win, c_win;
  logic [7:0]      a, b, c, x;
  logic            out_free, r_adv, we;
  logic [7:0]      o_byte_q;
  logic            o_row_end_q, o_image_end_q, o_bad_q;

  assign out_free = !o_vld_q || out_o.ready;
  assign r_adv    = r_vld_q && out_free;
  assign pop_o    = !fifo_st_i.empty && (!r_vld_q || r_adv);
  assign we       = r_adv && !r_q.is_err;

  always_comb begin
    a_win = r_q.row_start ? 32'd0 : win_a_q;
    c_win = r_q.row_start ? 32'd0 : win_c_q;
    a     = a_win[{pix_sel_i, 3'b000} +: 8];
    c     = c_win[{pix_sel_i, 3'b000} +: 8];
    b     = r_q.first_row ? 8'd0 : (byp_q ? byp_data_q : rd_q);
    x     = r_q.data + predict(r_q.filt, a, b, c);
  end

  always_ff @(posedge clk_i) begin
    if (we) line_mem[r_q.col] <= x;
    if (pop_o) begin
      rd_q       <= line_mem[head_i.col];
      byp_q      <= we && (r_q.col == head_i.col);
      byp_data_q <= x;
      r_q        <= head_i;
    end
    if (we) begin
      win_a_q <= {a_win[23:0], x};
      win_c_q <= {c_win[23:0], b};
    end
    if (r_adv) begin
      o_byte_q      <= r_q.is_err ? 8'd0 : x;
      o_row_end_q   <= !r_q.is_err && r_q.row_end;
      o_image_end_q <= !r_q.is_err && r_q.image_end;
      o_bad_q       <= r_q.is_err;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_vld_q <= 1'b0;
      o_vld_q <= 1'b0;
    end else begin
      if (pop_o)      r_vld_q <= 1'b1;
      else if (r_adv) r_vld_q <= 1'b0;
      if (r_adv)             o_vld_q <= 1'b1;
      else if (out_o.ready)  o_vld_q <= 1'b0;
    end
  end

  assign out_o.valid      = o_vld_q;
  assign out_o.pixel_byte = o_byte_q;
  assign out_o.row_end    = o_row_end_q;
  assign out_o.image_end  = o_image_end_q;
  assign out_o.bad_filter = o_bad_q;

endmodule
`default_nettype wire

// ===== rtl/core/png_scanline_unfilter_top.sv =====
// Top level of the PNG scanline unfilter: config registers, front, queue, back.
// Depends on psu_pkg, psu_if, psu_front, psu_fifo, psu_back and the macro header.
//
//   channel  dir  payload                                         handshake
//   in_i     in   stream_byte[7:0]                                valid/ready
//   out_o    out  pixel_byte[7:0] row_end image_end bad_filter    valid/ready
//   cfg_i    in   index[1:0] data[15:0]                           valid/ready
//
// One byte per cycle sustained while the output is not stalled; a data byte passes
// through the queue, the line store read and the result register to the output.
// Reset needs no clearing pass; the line store is read only where written before.
// An output stall fills the four-entry queue before in_i.ready drops.
// cfg_i.ready is always high.
`default_nettype none
`include "png_scanline_unfilter_top_macros.svh"
module png_scanline_unfilter_top (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  psu_in_if.sink    in_i,
  psu_out_if.source out_o,
  psu_cfg_if.sink   cfg_i
);

  logic [psu_pkg::PIX_W-1:0] pix_q;
  logic [psu_pkg::RB_W-1:0]  rb_q;
  logic [psu_pkg::RC_W-1:0]  rc_q;
  psu_pkg::cfg_t             cfg;
  psu_pkg::fifo_st_t         fifo_st;
  psu_pkg::entry_t           entry, head;
  logic                      push, pop;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_q <= psu_pkg::PIX_W'(1);
      rb_q  <= psu_pkg::RB_W'(1);
      rc_q  <= psu_pkg::RC_W'(1);
    end else if (cfg_i.valid) begin
      unique case (psu_pkg::cfg_idx_e'(cfg_i.index))
        psu_pkg::CFG_PIXEL_BYTES: pix_q <= cfg_i.data[psu_pkg::PIX_W-1:0];
        psu_pkg::CFG_ROW_BYTES:   rb_q  <= cfg_i.data[psu_pkg::RB_W-1:0];
        psu_pkg::CFG_ROW_COUNT:   rc_q  <= cfg_i.data[psu_pkg::RC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (pix_q == '0)        cfg.pix_sel = 2'd0;
    else if (pix_q > 3'd4)  cfg.pix_sel = 2'd3;
    else                    cfg.pix_sel = 2'(pix_q - 3'd1);
    if (rb_q == '0) cfg.row_bytes = psu_pkg::RB_W'(1);
    else if (32'(rb_q) > psu_pkg::MAX_ROW_BYTES)
      cfg.row_bytes = psu_pkg::RB_W'(psu_pkg::MAX_ROW_BYTES);
    else cfg.row_bytes = rb_q;
    cfg.row_count = (rc_q == '0) ? psu_pkg::RC_W'(1) : rc_q;
  end

  psu_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (in_i.valid),
    .in_byte_i  (in_i.stream_byte),
    .in_ready_o (in_i.ready),
    .fifo_st_i  (fifo_st),
    .push_o     (push),
    .entry_o    (entry)
  );

  psu_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .entry_i  (entry),
    .pop_i    (pop),
    .head_o   (head),
    .status_o (fifo_st)
  );

  psu_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .pix_sel_i (cfg.pix_sel),
    .head_i    (head),
    .fifo_st_i (fifo_st),
    .pop_o     (pop),
    .out_o     (out_o)
  );

  `PSU_ASSERT_NEVER(a_push_when_full, push && fifo_st.full, "push into full queue")
  `PSU_ASSERT_NEVER(a_pop_when_empty, pop && fifo_st.empty, "pop from empty queue")
  `PSU_ASSERT(a_bad_clean, out_o.valid && out_o.bad_filter |-> out_o.pixel_byte == 8'd0 && !out_o.row_end && !out_o.image_end, "error beat carries data")
  `PSU_ASSERT(a_img_row, out_o.valid && out_o.image_end |-> out_o.row_end, "image end without row end")

endmodule
`default_nettype wire
